// ===== rtl/assert_macros.svh =====
// Assertion macros for the incubator climate controller RTL.
// Used by files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check on every clock outside reset
`define ICC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("icc assertion failed");
// check in the cycle after a trigger condition
`define ICC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("icc assertion failed");
`else
`define ICC_ASSERT(lbl, prop)
`define ICC_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== rtl/icc_pkg.sv =====
// Package for the incubator climate controller: types, codes, egg tables.
// No dependencies; imported by every module of the block.
package icc_pkg;

  localparam logic [19:0] TicksPerDay = 20'd864000;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_SAMPLE = 2'd1,
    ACT_SELECT = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_HEN   = 2'd1,
    KIND_DUCK  = 2'd2,
    KIND_QUAIL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_TEMP_BAND    = 3'd0,
    CFG_TEMP_RELEASE = 3'd1,
    CFG_HUM_HIGH_ON  = 3'd2,
    CFG_HUM_HIGH_OFF = 3'd3,
    CFG_HUM_LOW_ON   = 3'd4,
    CFG_HUM_LOW_OFF  = 3'd5
  } cfg_idx_e;

  // drive level bits
  localparam int unsigned DrvHeater = 0;
  localparam int unsigned DrvCooler = 1;
  localparam int unsigned DrvFan    = 2;
  localparam int unsigned DrvTurner = 3;

  // alert bits (latches use 0..3, new-alert word adds turning start)
  localparam int unsigned AlrTempHi = 0;
  localparam int unsigned AlrTempLo = 1;
  localparam int unsigned AlrHumHi  = 2;
  localparam int unsigned AlrHumLo  = 3;
  localparam int unsigned AlrTurn   = 4;

  typedef struct packed {
    logic [8:0] temp_band;
    logic [8:0] temp_release;
    logic [9:0] hum_high_on;
    logic [9:0] hum_high_off;
    logic [9:0] hum_low_on;
    logic [9:0] hum_low_off;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [13:0] temperature_centi;
    logic [9:0]        humidity_tenths;
    logic [1:0]        egg_kind;
  } item_t;

  typedef struct packed {
    logic [3:0] drives;
    logic [4:0] new_alerts;
    logic [9:0] humidity_target_tenths;
    logic [8:0] incubation_day;
    logic [1:0] active_kind;
  } res_t;

  function automatic logic [16:0] kind_period(logic [1:0] k);
    logic [16:0] p;
    case (k)
      KIND_HEN:  p = 17'd72000;
      KIND_DUCK: p = 17'd108000;
      default:   p = 17'd36000;
    endcase
    return p;
  endfunction

  // first tick count past which the turner runs: period minus turning length
  function automatic logic [16:0] kind_turn_start(logic [1:0] k);
    logic [16:0] s;
    case (k)
      KIND_HEN:  s = 17'd71550;
      KIND_DUCK: s = 17'd107400;
      default:   s = 17'd35700;
    endcase
    return s;
  endfunction

  function automatic logic signed [14:0] kind_target(logic [1:0] k);
    logic signed [14:0] t;
    case (k)
      KIND_DUCK: t = 15'sd3775;
      default:   t = 15'sd3765;
    endcase
    return t;
  endfunction

  function automatic logic [9:0] hum_target(logic [1:0] k, logic [7:0] day);
    logic [9:0] h;
    case (k)
      KIND_HEN:   h = (day < 8'd18) ? 10'd525 : 10'd675;
      KIND_DUCK:  h = (day < 8'd14) ? 10'd525 : 10'd675;
      KIND_QUAIL: h = (day < 8'd25) ? 10'd575 : 10'd725;
      default:    h = 10'd0;
    endcase
    return h;
  endfunction

endpackage

// ===== rtl/incubator_climate_controller.sv =====
// Top level of the incubator climate controller: handshakes, input and result words.
// Depends on icc_pkg, icc_cfg_regs and icc_core.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   action, temperature_centi, humidity_tenths, egg_kind
//   out      out_valid_o / out_ready_i heat/cool/fan/turner drives, new_alerts, hum target, day, kind
//   cfg      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// Each word is registered in the input register, then moves into the result
// register; one word per clock sustained while the result side takes each word.
// The state update happens in one pass as the word moves into the result
// register. A stalled result holds the word in the input register, so the
// input takes at most one more word and then stalls; ready returns in the cycle the
// result drains. Reset clears state and valids and loads default thresholds.
module incubator_climate_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic signed [13:0] temperature_centi_i,
  input  logic [9:0]        humidity_tenths_i,
  input  logic [1:0]        egg_kind_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              heat_drive_o,
  output logic              cool_drive_o,
  output logic              fan_on_o,
  output logic              turner_on_o,
  output logic [4:0]        new_alerts_o,
  output logic [9:0]        humidity_target_tenths_o,
  output logic [8:0]        incubation_day_o,
  output logic [1:0]        active_kind_o,
  // configuration writes
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [9:0]        cfg_data_i
);
  import icc_pkg::*;

  logic  in_valid_q, in_valid_d;
  item_t item_q, item_d;
  logic  out_valid_q, out_valid_d;
  res_t  res_q, res_d;
  res_t  core_res;
  cfg_t  cfg;
  logic  advance;

  // input word moves on when the result register is free or draining now
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    item_d     = item_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d               = 1'b1;
      item_d.action            = action_i;
      item_d.temperature_centi = temperature_centi_i;
      item_d.humidity_tenths   = humidity_tenths_i;
      item_d.egg_kind          = egg_kind_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (advance) begin
      out_valid_d = 1'b1;
      res_d       = core_res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  icc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  icc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (core_res)
  );

  assign out_valid_o              = out_valid_q;
  assign heat_drive_o             = res_q.drives[DrvHeater];
  assign cool_drive_o             = res_q.drives[DrvCooler];
  assign fan_on_o                 = res_q.drives[DrvFan];
  assign turner_on_o              = res_q.drives[DrvTurner];
  assign new_alerts_o             = res_q.new_alerts;
  assign humidity_target_tenths_o = res_q.humidity_target_tenths;
  assign incubation_day_o         = res_q.incubation_day;
  assign active_kind_o            = res_q.active_kind;

endmodule

// ===== rtl/icc_cfg_regs.sv =====
// Configuration register file: thresholds for temperature band and humidity alerts.
// Depends on icc_pkg.
module icc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [2:0]    idx_i,
  input  logic [9:0]    data_i,
  output icc_pkg::cfg_t cfg_o
);
  import icc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_TEMP_BAND:    cfg_d.temp_band    = data_i[8:0];
        CFG_TEMP_RELEASE: cfg_d.temp_release = data_i[8:0];
        CFG_HUM_HIGH_ON:  cfg_d.hum_high_on  = data_i;
        CFG_HUM_HIGH_OFF: cfg_d.hum_high_off = data_i;
        CFG_HUM_LOW_ON:   cfg_d.hum_low_on   = data_i;
        CFG_HUM_LOW_OFF:  cfg_d.hum_low_off  = data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_band    <= 9'd50;
      cfg_q.temp_release <= 9'd30;
      cfg_q.hum_high_on  <= 10'd800;
      cfg_q.hum_high_off <= 10'd780;
      cfg_q.hum_low_on   <= 10'd400;
      cfg_q.hum_low_off  <= 10'd420;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/icc_core.sv =====
// Controller state and single-pass update: turning window, day count, thermostat, alerts.
// Depends on icc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module icc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  icc_pkg::item_t item_i,
  input  icc_pkg::cfg_t  cfg_i,
  output icc_pkg::res_t  res_o
);
  import icc_pkg::*;

  logic [1:0]  kind_q, kind_d;
  logic [16:0] turn_q, turn_d;
  logic [19:0] day_ticks_q, day_ticks_d;
  logic [7:0]  day_q, day_d;
  logic [3:0]  alert_q, alert_d;
  logic [3:0]  drive_q, drive_d;
  logic [4:0]  news;

  logic [16:0] turn_inc;
  logic [19:0] day_ticks_inc;
  logic [16:0] per;
  logic [16:0] turn_start;
  logic signed [14:0] temp_s;
  logic signed [14:0] sp;
  logic signed [14:0] band_s;
  logic signed [14:0] rel_s;

  assign turn_inc      = turn_q + 17'd1;
  assign day_ticks_inc = day_ticks_q + 20'd1;
  assign per           = kind_period(kind_q);
  assign turn_start    = kind_turn_start(kind_q);
  assign temp_s        = {item_i.temperature_centi[13], item_i.temperature_centi};
  assign sp            = kind_target(kind_q);
  assign band_s        = signed'({6'd0, cfg_i.temp_band});
  assign rel_s         = signed'({6'd0, cfg_i.temp_release});

  always_comb begin
    kind_d      = kind_q;
    turn_d      = turn_q;
    day_ticks_d = day_ticks_q;
    day_d       = day_q;
    alert_d     = alert_q;
    drive_d     = drive_q;
    news        = '0;
    unique case (action_e'(item_i.action))
      ACT_TICK: begin
        if (day_ticks_inc >= TicksPerDay) begin
          day_ticks_d = '0;
          if (day_q != 8'hFF) day_d = day_q + 8'd1;
        end else begin
          day_ticks_d = day_ticks_inc;
        end
        turn_d = turn_inc;
        if (kind_q != KIND_NONE) begin
          if (turn_inc > turn_start && turn_inc < per) begin
            if (!drive_q[DrvTurner]) news[AlrTurn] = 1'b1;
            drive_d[DrvTurner] = 1'b1;
          end else begin
            drive_d[DrvTurner] = 1'b0;
          end
          if (turn_inc > per) turn_d = '0;
        end
      end
      ACT_SAMPLE: begin
        if (kind_q != KIND_NONE) begin
          drive_d[DrvFan] = 1'b1;
          if (temp_s >= sp + band_s) begin
            drive_d[DrvHeater] = 1'b0;
            drive_d[DrvCooler] = 1'b1;
            if (!alert_q[AlrTempHi]) begin
              alert_d[AlrTempHi] = 1'b1;
              news[AlrTempHi]    = 1'b1;
            end
          end else if (temp_s <= sp - band_s) begin
            drive_d[DrvHeater] = 1'b1;
            drive_d[DrvCooler] = 1'b0;
            if (!alert_q[AlrTempLo]) begin
              alert_d[AlrTempLo] = 1'b1;
              news[AlrTempLo]    = 1'b1;
            end
          end else begin
            drive_d[DrvHeater] = 1'b0;
            drive_d[DrvCooler] = 1'b0;
            if (temp_s < sp + rel_s) alert_d[AlrTempHi] = 1'b0;
            if (temp_s > sp - rel_s) alert_d[AlrTempLo] = 1'b0;
          end
          if (item_i.humidity_tenths >= cfg_i.hum_high_on) begin
            if (!alert_q[AlrHumHi]) begin
              alert_d[AlrHumHi] = 1'b1;
              news[AlrHumHi]    = 1'b1;
            end
          end else if (item_i.humidity_tenths <= cfg_i.hum_low_on) begin
            if (!alert_q[AlrHumLo]) begin
              alert_d[AlrHumLo] = 1'b1;
              news[AlrHumLo]    = 1'b1;
            end
          end else begin
            if (item_i.humidity_tenths <= cfg_i.hum_high_off) alert_d[AlrHumHi] = 1'b0;
            if (item_i.humidity_tenths >= cfg_i.hum_low_off) alert_d[AlrHumLo] = 1'b0;
          end
        end
      end
      ACT_SELECT: begin
        if (item_i.egg_kind != KIND_NONE) begin
          kind_d      = item_i.egg_kind;
          day_d       = '0;
          day_ticks_d = '0;
        end
      end
      default: ;  // unused code: report state only
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_NONE;
      turn_q      <= '0;
      day_ticks_q <= '0;
      day_q       <= '0;
      alert_q     <= '0;
      drive_q     <= '0;
    end else if (fire_i) begin
      kind_q      <= kind_d;
      turn_q      <= turn_d;
      day_ticks_q <= day_ticks_d;
      day_q       <= day_d;
      alert_q     <= alert_d;
      drive_q     <= drive_d;
    end
  end

  assign res_o.drives                 = drive_d;
  assign res_o.new_alerts             = news;
  assign res_o.humidity_target_tenths = hum_target(kind_d, day_d);
  assign res_o.incubation_day         = {1'b0, day_d} + 9'd1;
  assign res_o.active_kind            = kind_d;

  `ICC_ASSERT(a_day_ticks_range, day_ticks_q < TicksPerDay)
  `ICC_ASSERT(a_turn_start_drives, fire_i |-> (!news[AlrTurn] || drive_d[DrvTurner]))
  `ICC_ASSERT_NEXT(a_turn_bounded, fire_i && item_i.action == ACT_TICK && kind_q != KIND_NONE, turn_q <= kind_period(kind_q))
  `ICC_ASSERT_NEXT(a_day_no_backstep, fire_i && item_i.action != ACT_SELECT, day_q >= $past(day_q))

endmodule

// ===== dv/incubator_climate_controller_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for incubator_climate_controller: thermostat, alerts, turning.
// Depends on icc_pkg and the controller RTL; builds its own prediction of every result.
module incubator_climate_controller_tb;
  import icc_pkg::*;

  // unused action code, handled as a no-op by the block
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned DAY_TICKS = 864000;
  // a word passes the input and result registers; let the block settle before touching registers
  localparam int unsigned SETTLE_CYCLES = 4;
  // generous limit, well clear of what a full run needs
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] action_i = '0;
  logic signed [13:0] temperature_centi_i = '0;
  logic [9:0] humidity_tenths_i = '0;
  logic [1:0] egg_kind_i = '0;

  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic heat_drive_o, cool_drive_o, fan_on_o, turner_on_o;
  logic [4:0] new_alerts_o;
  logic [9:0] humidity_target_tenths_o;
  logic [8:0] incubation_day_o;
  logic [1:0] active_kind_o;

  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [9:0] cfg_data_i = '0;

  incubator_climate_controller DUT (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .action_i                 (action_i),
    .temperature_centi_i      (temperature_centi_i),
    .humidity_tenths_i        (humidity_tenths_i),
    .egg_kind_i               (egg_kind_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .heat_drive_o             (heat_drive_o),
    .cool_drive_o             (cool_drive_o),
    .fan_on_o                 (fan_on_o),
    .turner_on_o              (turner_on_o),
    .new_alerts_o             (new_alerts_o),
    .humidity_target_tenths_o (humidity_target_tenths_o),
    .incubation_day_o         (incubation_day_o),
    .active_kind_o            (active_kind_o),
    .cfg_we_i                 (cfg_we_i),
    .cfg_idx_i                (cfg_idx_i),
    .cfg_data_i               (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Controller state as the bench sees it. Thresholds start at their reset values.
  // ---------------------------------------------------------------------------
  logic [8:0]  th_band = 9'd50;
  logic [8:0]  th_release = 9'd30;
  logic [9:0]  th_hum_hi_on = 10'd800;
  logic [9:0]  th_hum_hi_off = 10'd780;
  logic [9:0]  th_hum_lo_on = 10'd400;
  logic [9:0]  th_hum_lo_off = 10'd420;

  kind_e       ctl_kind = KIND_NONE;
  logic [16:0] ctl_turn = '0;
  logic [19:0] ctl_day_ticks = '0;
  logic [7:0]  ctl_day = '0;
  logic [3:0]  ctl_latch = '0;   // temp hi, temp lo, hum hi, hum lo
  logic [3:0]  ctl_drive = '0;   // heater, cooler, fan, turner

  item_t pending_words[$];        // words waiting for the driver
  res_t  expected_status[$];      // predicted result words, oldest first

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          word_taken = 1'b0;  // set at the edge that took the offered word
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  function automatic int turn_period(kind_e k);
    case (k)
      KIND_HEN:  return 72000;
      KIND_DUCK: return 108000;
      default:   return 36000;
    endcase
  endfunction

  // ticks of each period during which the turner runs
  function automatic int turn_length(kind_e k);
    case (k)
      KIND_HEN:  return 450;
      KIND_DUCK: return 600;
      default:   return 300;
    endcase
  endfunction

  function automatic int setpoint_for(kind_e k);
    return (k == KIND_DUCK) ? 3775 : 3765;
  endfunction

  // humidity schedule: later, wetter target from a fixed day on
  function automatic logic [9:0] humidity_plan(kind_e k, logic [7:0] day);
    case (k)
      KIND_HEN:   return (day < 8'd18) ? 10'd525 : 10'd675;
      KIND_DUCK:  return (day < 8'd14) ? 10'd525 : 10'd675;
      KIND_QUAIL: return (day < 8'd25) ? 10'd575 : 10'd725;
      default:    return 10'd0;
    endcase
  endfunction

  // Advance the bench copy of the controller by one word, return the result word.
  function automatic res_t predict_status(item_t w);
    res_t r;
    logic [4:0] raised;
    int t, h, sp, per, len;
    raised = '0;
    t = int'($signed(w.temperature_centi));
    h = int'(w.humidity_tenths);
    case (w.action)
      ACT_TICK: begin
        // days count on their own, kind or not, and stop at 255
        ctl_day_ticks = ctl_day_ticks + 20'd1;
        if (ctl_day_ticks >= DAY_TICKS) begin
          ctl_day_ticks = '0;
          if (ctl_day != 8'd255) ctl_day = ctl_day + 8'd1;
        end
        ctl_turn = ctl_turn + 17'd1;  // free 17-bit wrap with no kind
        if (ctl_kind != KIND_NONE) begin
          per = turn_period(ctl_kind);
          len = turn_length(ctl_kind);
          if (int'(ctl_turn) > per - len && int'(ctl_turn) < per) begin
            if (!ctl_drive[DrvTurner]) raised[AlrTurn] = 1'b1;
            ctl_drive[DrvTurner] = 1'b1;
          end else begin
            ctl_drive[DrvTurner] = 1'b0;
          end
          if (int'(ctl_turn) > per) ctl_turn = '0;
        end
      end
      ACT_SAMPLE: begin
        if (ctl_kind != KIND_NONE) begin
          sp = setpoint_for(ctl_kind);
          ctl_drive[DrvHeater] = 1'b0;
          ctl_drive[DrvCooler] = 1'b0;
          ctl_drive[DrvFan] = 1'b1;
          if (t >= sp + int'(th_band)) begin
            ctl_drive[DrvCooler] = 1'b1;
            if (!ctl_latch[AlrTempHi]) raised[AlrTempHi] = 1'b1;
            ctl_latch[AlrTempHi] = 1'b1;
          end else if (t <= sp - int'(th_band)) begin
            ctl_drive[DrvHeater] = 1'b1;
            if (!ctl_latch[AlrTempLo]) raised[AlrTempLo] = 1'b1;
            ctl_latch[AlrTempLo] = 1'b1;
          end else begin
            if (t < sp + int'(th_release)) ctl_latch[AlrTempHi] = 1'b0;
            if (t > sp - int'(th_release)) ctl_latch[AlrTempLo] = 1'b0;
          end
          if (h >= int'(th_hum_hi_on)) begin
            if (!ctl_latch[AlrHumHi]) raised[AlrHumHi] = 1'b1;
            ctl_latch[AlrHumHi] = 1'b1;
          end else if (h <= int'(th_hum_lo_on)) begin
            if (!ctl_latch[AlrHumLo]) raised[AlrHumLo] = 1'b1;
            ctl_latch[AlrHumLo] = 1'b1;
          end else begin
            if (h <= int'(th_hum_hi_off)) ctl_latch[AlrHumHi] = 1'b0;
            if (h >= int'(th_hum_lo_off)) ctl_latch[AlrHumLo] = 1'b0;
          end
        end
      end
      ACT_SELECT: begin
        // selection restarts the day count but keeps turning, latches and drives
        if (w.egg_kind != KIND_NONE) begin
          ctl_kind = kind_e'(w.egg_kind);
          ctl_day = '0;
          ctl_day_ticks = '0;
        end
      end
      default: ;
    endcase
    r.drives = ctl_drive;
    r.new_alerts = raised;
    r.humidity_target_tenths = humidity_plan(ctl_kind, ctl_day);
    r.incubation_day = {1'b0, ctl_day} + 9'd1;
    r.active_kind = ctl_kind;
    return r;
  endfunction

  function automatic item_t make_word(logic [1:0] act, int t, int h, logic [1:0] k);
    item_t w;
    w.action = act;
    w.temperature_centi = t[13:0];
    w.humidity_tenths = h[9:0];
    w.egg_kind = k;
    return w;
  endfunction

  // Random word: values mostly near the setpoints and thresholds, some raw noise.
  function automatic item_t random_word();
    item_t w;
    int unsigned pick;
    int t, h;
    int marks[4];
    pick = $urandom_range(99);
    if (pick < 35) w.action = ACT_TICK;
    else if (pick < 80) w.action = ACT_SAMPLE;
    else if (pick < 94) w.action = ACT_SELECT;
    else w.action = ACT_UNUSED;
    if ($urandom_range(9) < 3) t = int'($urandom_range(16383));  // any 14-bit code
    else t = 3770 + int'($urandom_range(1200)) - 600;
    marks = '{int'(th_hum_hi_on), int'(th_hum_hi_off), int'(th_hum_lo_on),
              int'(th_hum_lo_off)};
    if ($urandom_range(9) < 3) h = int'($urandom_range(1023));
    else h = marks[$urandom_range(3)] + int'($urandom_range(6)) - 3;
    if (h < 0) h = 0;
    if (h > 1023) h = 1023;
    w.temperature_centi = t[13:0];
    w.humidity_tenths = h[9:0];
    w.egg_kind = 2'($urandom_range(3));
    return w;
  endfunction

  task automatic note_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Wait for the pipe to empty: nothing queued, nothing offered, nothing owed.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic write_reg(cfg_idx_e idx, logic [9:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TEMP_BAND:    th_band = val[8:0];
      CFG_TEMP_RELEASE: th_release = val[8:0];
      CFG_HUM_HIGH_ON:  th_hum_hi_on = val;
      CFG_HUM_HIGH_OFF: th_hum_hi_off = val;
      CFG_HUM_LOW_ON:   th_hum_lo_on = val;
      CFG_HUM_LOW_OFF:  th_hum_lo_off = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_thresholds(int band, int rel, int hi_on, int hi_off, int lo_on,
                                  int lo_off);
    write_reg(CFG_TEMP_BAND, band[9:0]);
    write_reg(CFG_TEMP_RELEASE, rel[9:0]);
    write_reg(CFG_HUM_HIGH_ON, hi_on[9:0]);
    write_reg(CFG_HUM_HIGH_OFF, hi_off[9:0]);
    write_reg(CFG_HUM_LOW_ON, lo_on[9:0]);
    write_reg(CFG_HUM_LOW_OFF, lo_off[9:0]);
  endtask

  // Random words, then the sender pauses until every result is back.
  task automatic send_random(int n);
    for (int i = 0; i < n; i++) pending_words.push_back(random_word());
    wait_quiet();
  endtask

  // Run of ticks with an occasional sample mixed in; samples keep the turner.
  task automatic send_ticks(int n);
    item_t w;
    for (int i = 0; i < n; i++) begin
      w = random_word();
      w.action = ACT_TICK;
      pending_words.push_back(w);
      if (i % 1000 == 999) begin
        w = random_word();
        w.action = ACT_SAMPLE;
        pending_words.push_back(w);
      end
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued word at the falling edge. Valid only drops
  // once the word went through, and never with a word half offered.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : word_driver
    item_t w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || word_taken) begin
      word_taken = 1'b0;
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid_i <= 1'b1;
        action_i <= w.action;
        temperature_centi_i <= w.temperature_centi;
        humidity_tenths_i <= w.humidity_tenths;
        egg_kind_i <= w.egg_kind;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side ready: random stalls, plus one long hold-off on request that
  // backs the block up until it drops in_ready_o.
  always @(negedge clk_i) begin : result_sink
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, check the result word leaving and predict
  // for the input word going in. The result is always older than the input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : status_monitor
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_status.size() == 0) begin
          note_mismatch("unexpected result word", 0, 1);
        end else begin
          want = expected_status.pop_front();
          if (heat_drive_o !== want.drives[DrvHeater])
            note_mismatch("heat_drive", want.drives[DrvHeater], heat_drive_o);
          if (cool_drive_o !== want.drives[DrvCooler])
            note_mismatch("cool_drive", want.drives[DrvCooler], cool_drive_o);
          if (fan_on_o !== want.drives[DrvFan])
            note_mismatch("fan_on", want.drives[DrvFan], fan_on_o);
          if (turner_on_o !== want.drives[DrvTurner])
            note_mismatch("turner_on", want.drives[DrvTurner], turner_on_o);
          if (new_alerts_o !== want.new_alerts)
            note_mismatch("new_alerts", want.new_alerts, new_alerts_o);
          if (humidity_target_tenths_o !== want.humidity_target_tenths)
            note_mismatch("humidity_target_tenths", want.humidity_target_tenths,
                          humidity_target_tenths_o);
          if (incubation_day_o !== want.incubation_day)
            note_mismatch("incubation_day", want.incubation_day, incubation_day_o);
          if (active_kind_o !== want.active_kind)
            note_mismatch("active_kind", want.active_kind, active_kind_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_status.push_back(predict_status(make_word(action_i,
            int'(temperature_centi_i), int'(humidity_tenths_i), egg_kind_i)));
        word_taken = 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus. Day rollover needs 864000 ticks per day, beyond this run, so the
  // day stays at one and the humidity targets stay on their early values. The
  // turning window opens tens of thousands of ticks in, also beyond this run.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first phase: slow sender, very slow receiver
    send_idle_pct = 27;
    recv_idle_pct = 84;
    write_thresholds(50, 30, 800, 780, 400, 420);

    // nothing selected yet: samples, kind zero and the unused code change nothing
    pending_words.push_back(make_word(ACT_SAMPLE, 8000, 1000, KIND_HEN));
    pending_words.push_back(make_word(ACT_SELECT, -4000, 0, KIND_NONE));
    pending_words.push_back(make_word(ACT_UNUSED, 8191, 1023, KIND_QUAIL));
    pending_words.push_back(make_word(ACT_TICK, -8192, 512, KIND_DUCK));
    // hen, setpoint 3765: cooler at the upper band edge, latches and their release
    pending_words.push_back(make_word(ACT_SELECT, 0, 0, KIND_HEN));
    pending_words.push_back(make_word(ACT_SAMPLE, 3815, 800, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 3815, 800, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 3795, 781, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 3794, 780, KIND_NONE));
    // heater at the lower band edge, low humidity, release just inside
    pending_words.push_back(make_word(ACT_SAMPLE, 3715, 400, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 3735, 419, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 3736, 420, KIND_NONE));
    // field extremes
    pending_words.push_back(make_word(ACT_SAMPLE, -8192, 0, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 8191, 1023, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, -4000, 1000, KIND_NONE));
    // duck has its own setpoint; quail its own humidity target
    pending_words.push_back(make_word(ACT_SELECT, 0, 0, KIND_DUCK));
    pending_words.push_back(make_word(ACT_SAMPLE, 3825, 600, KIND_NONE));
    pending_words.push_back(make_word(ACT_SAMPLE, 3775, 600, KIND_NONE));
    pending_words.push_back(make_word(ACT_SELECT, 0, 0, KIND_QUAIL));
    pending_words.push_back(make_word(ACT_SAMPLE, 3765, 575, KIND_NONE));
    pending_words.push_back(make_word(ACT_SELECT, 0, 0, KIND_NONE));
    pending_words.push_back(make_word(ACT_UNUSED, 0, 0, KIND_HEN));
    pending_words.push_back(make_word(ACT_TICK, 0, 0, KIND_NONE));
    wait_quiet();
    send_random(90);
    send_random(90);

    // second phase: roles swapped, extreme thresholds
    send_idle_pct = 84;
    recv_idle_pct = 27;
    write_thresholds(0, 0, 1000, 1000, 0, 0);
    send_random(90);
    // widest band, release as wide as the band, thresholds beyond their range
    write_thresholds(511, 511, 0, 1023, 1023, 0);
    send_random(90);

    // third phase: no idling, a release wider than the band
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_thresholds(20, 60, 700, 650, 450, 500);
    for (int i = 0; i < 90; i++) pending_words.push_back(random_word());
    // long hold-off on the result side while the sender keeps offering
    @(posedge clk_i);
    hold_request = 1'b1;
    wait_quiet();
    write_thresholds(500, 500, 1000, 0, 1000, 0);
    send_random(90);

    // kind switches with ticks in between, early in the turning count
    write_thresholds(50, 30, 800, 780, 400, 420);
    pending_words.push_back(make_word(ACT_SELECT, 0, 0, KIND_QUAIL));
    send_ticks(20);
    pending_words.push_back(make_word(ACT_SELECT, 0, 0, KIND_DUCK));
    send_ticks(20);

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
